>>> hdl/alr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alr_pkg;

	// Default sizing of the block.
	localparam int DEF_MAX_LENGTH  = 4096;
	localparam int DEF_SAMPLE_BITS = 24;

	// Configuration port layout.
	localparam int CFG_W       = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int MAX_RATIO   = 63;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_INPUT_LENGTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LENGTH = 2'd1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_ACCUM,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_EMIT,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic accum;
		logic div_start;
		logic emit;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cell_full;
		logic rem_zero;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

>>> hdl/area_based_line_resampler.sv
`timescale 1ns / 1ps
`default_nettype none

// Area-based line resampler: turns a row of input_length samples into
// output_length samples by integrating the input over each output cell and
// dividing by input_length, rounding toward negative infinity. Each accepted
// sample produces zero or more output requests; run_end marks the last one
// caused by a sample and row_end marks the last output of a row. One sample
// is processed at a time: a new one is taken only after it has been spread
// over all its cell passes and each output that it closes is emitted, which
// a stalled output side delays. The divider that closes each output cell
// makes one quotient bit per cycle. A finished output waits in an output
// register while the core moves on. An accepted length write clears the row
// in progress; writes out of range or above the 63:1 ratio are ignored.
module area_based_line_resampler
	import alr_pkg::*;
#(
	parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic                               run_end,
	output logic                               row_end
);

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	alr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	// Accumulator, divider, counters and output register.
	alr_datapath #(
		.MAX_LENGTH (MAX_LENGTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.run_end   (run_end),
		.row_end   (row_end)
	);

endmodule

`default_nettype wire

>>> hdl/alr_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module alr_divider #(
	parameter int SAMPLE_BITS = 24,
	parameter int LEN_W       = 13
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [SAMPLE_BITS+LEN_W-1:0] dividend,
	input  wire logic [LEN_W-1:0]             divisor,
	output logic                              busy,
	output logic [SAMPLE_BITS-1:0]            quotient
);

	localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

	logic [CNT_W-1:0]       cnt_q;
	logic [LEN_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] quo_q;
	logic [LEN_W:0]         trial;
	logic [LEN_W:0]         diff;
	logic                   fits;

	// One restoring step: bring down the next dividend bit and try to subtract.
	always_comb begin
		trial = {rem_q, quo_q[SAMPLE_BITS-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	// Iteration counter; the unit is busy while steps remain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SAMPLE_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Partial remainder and quotient shift register. The upper dividend bits
	// are already below the divisor, so only the low bits need steps.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SAMPLE_BITS+LEN_W-1:SAMPLE_BITS];
			quo_q <= dividend[SAMPLE_BITS-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			quo_q <= {quo_q[SAMPLE_BITS-2:0], fits};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> hdl/alr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module alr_datapath
	import alr_pkg::*;
#(
	parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmd_t                          cmd,
	output status_t                            status,
	input  wire logic                          cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic                               run_end,
	output logic                               row_end
);

	localparam int LEN_W = $clog2(MAX_LENGTH + 1);
	localparam int ACC_W = SAMPLE_BITS + LEN_W;

	logic [LEN_W-1:0]              n_q;
	logic [LEN_W-1:0]              m_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [LEN_W-1:0]              remaining_q;
	logic [LEN_W-1:0]              filled_q;
	logic [LEN_W-1:0]              inputs_seen_q;
	logic [LEN_W-1:0]              outputs_sent_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       prod_s1;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          run_end_q;
	logic                          row_end_q;

	logic [LEN_W-1:0]              open_units;
	logic [LEN_W-1:0]              take;
	logic signed [ACC_W:0]         prod_full;
	logic [ACC_W:0]                biased_full;
	logic [ACC_W-1:0]              biased;
	logic                          div_busy;
	logic [SAMPLE_BITS-1:0]        quotient;
	logic                          len_ok;
	logic                          n_write_ok;
	logic                          m_write_ok;
	logic                          cfg_apply;
	logic [LEN_W:0]                seen_next;

	// Units to cover in this pass: what the open cell still lacks, at most
	// what the sample has left.
	always_comb begin
		open_units = n_q - filled_q;
		take       = (open_units > remaining_q) ? remaining_q : open_units;
		prod_full  = sample_q * $signed({1'b0, take});
	end

	// Bias the closed sum by n * 2^(SAMPLE_BITS-1) so the divider sees a
	// non-negative value; flipping the quotient sign bit removes the bias
	// and yields floor division.
	always_comb begin
		biased_full = {acc_q[ACC_W-1], acc_q}
			+ {1'b0, (ACC_W'(n_q) << (SAMPLE_BITS - 1))};
		biased      = biased_full[ACC_W-1:0];
	end

	alr_divider #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.LEN_W      (LEN_W)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(biased),
		.divisor (n_q),
		.busy    (div_busy),
		.quotient(quotient)
	);

	// Length write checks: range, then the output-to-input ratio limit.
	always_comb begin
		len_ok     = (cfg_data != '0) && (32'(cfg_data) <= 32'(MAX_LENGTH));
		n_write_ok = len_ok && (32'(m_q) <= 32'(cfg_data) * 32'(MAX_RATIO));
		m_write_ok = len_ok && (32'(cfg_data) <= 32'(n_q) * 32'(MAX_RATIO));
		cfg_apply  = 1'b0;
		if (cfg_write) begin
			unique case (cfg_index)
				REG_INPUT_LENGTH:  cfg_apply = n_write_ok;
				REG_OUTPUT_LENGTH: cfg_apply = m_write_ok;
				default:           cfg_apply = 1'b0;
			endcase
		end
	end

	// Length registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= LEN_W'(1);
			m_q <= LEN_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_INPUT_LENGTH: begin
					if (n_write_ok) n_q <= LEN_W'(cfg_data);
				end
				REG_OUTPUT_LENGTH: begin
					if (m_write_ok) m_q <= LEN_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign seen_next = {1'b0, inputs_seen_q} + 1'b1;

	// Row state: open cell, counters and the sample being spread.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			filled_q       <= '0;
			inputs_seen_q  <= '0;
			outputs_sent_q <= '0;
			remaining_q    <= '0;
		end else if (cfg_apply) begin
			acc_q          <= '0;
			filled_q       <= '0;
			inputs_seen_q  <= '0;
			outputs_sent_q <= '0;
		end else begin
			if (cmd.load) begin
				remaining_q <= m_q;
			end
			if (cmd.step) begin
				filled_q    <= filled_q + take;
				remaining_q <= remaining_q - take;
			end
			if (cmd.accum) begin
				acc_q <= acc_q + prod_s1;
			end
			if (cmd.emit) begin
				acc_q          <= '0;
				filled_q       <= '0;
				outputs_sent_q <= outputs_sent_q + 1'b1;
			end
			if (cmd.finish) begin
				if (seen_next >= {1'b0, n_q}) begin
					acc_q          <= '0;
					filled_q       <= '0;
					inputs_seen_q  <= '0;
					outputs_sent_q <= '0;
				end else begin
					inputs_seen_q <= seen_next[LEN_W-1:0];
				end
			end
		end
	end

	// Sample capture and registered product.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample_in;
		end
		if (cmd.step) begin
			prod_s1 <= prod_full[ACC_W-1:0];
		end
	end

	// Output register: a request waits here while the core goes on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sample_out_q <= $signed({~quotient[SAMPLE_BITS-1], quotient[SAMPLE_BITS-2:0]});
			run_end_q    <= (remaining_q < n_q);
			row_end_q    <= ((outputs_sent_q + 1'b1) == m_q);
		end
	end

	always_comb begin
		status.cell_full = (filled_q == n_q);
		status.rem_zero  = (remaining_q == '0);
		status.div_busy  = div_busy;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign run_end    = run_end_q;
	assign row_end    = row_end_q;

endmodule

`default_nettype wire

>>> hdl/alr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module alr_ctrl
	import alr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				if (status.cell_full) begin
					state_d = ST_DIV_START;
				end else if (status.rem_zero) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (!status.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = status.rem_zero ? ST_FINISH : ST_STEP;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sim/area_based_line_resampler_tb.sv
`timescale 1ns / 1ps

module area_based_line_resampler_tb;
	import alr_pkg::*;

	localparam int SW = DEF_SAMPLE_BITS;
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

	// Indexes that the block does not decode.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

	localparam int RANDOM_ITEMS  = 360;
	localparam int QUIET_FROM    = 300;
	localparam int SETTLE_CYCLES = 2000;
	localparam int HOLD_CYCLES   = 400;
	localparam longint TIMEOUT_NS = 64'd60_000_000;

	typedef struct {
		logic signed [SW-1:0] sample;
		logic                 run_end;
		logic                 row_end;
	} resampled_t;

	// Tracks the open output cell of the row and queues the outputs each sample closes.
	class cell_area_predictor;
		int in_len;
		int out_len;
		longint area;
		int filled;
		int taken;
		int emitted;
		int errors;
		resampled_t due_outputs[$];

		function new();
			in_len  = 1;
			out_len = 1;
			errors  = 0;
			clear_row();
		endfunction

		function void clear_row();
			area    = 0;
			filled  = 0;
			taken   = 0;
			emitted = 0;
		endfunction

		// A length write takes effect only if it is in range and keeps the ratio legal.
		function void write_length(logic [CFG_INDEX_W-1:0] index, logic [CFG_W-1:0] data);
			int v;
			v = int'(data);
			if (index == REG_INPUT_LENGTH) begin
				if (v == 0 || v > DEF_MAX_LENGTH)
					return;
				if (out_len > MAX_RATIO * v)
					return;
				in_len = v;
				clear_row();
			end else if (index == REG_OUTPUT_LENGTH) begin
				if (v == 0 || v > DEF_MAX_LENGTH)
					return;
				if (v > MAX_RATIO * in_len)
					return;
				out_len = v;
				clear_row();
			end
		endfunction

		// Spread one sample over the output cells it covers.
		function void take_sample(logic signed [SW-1:0] s);
			longint value;
			longint quotient;
			int remaining;
			int portion;
			resampled_t r;
			value = s;
			remaining = out_len;
			while (remaining > 0) begin
				portion = in_len - filled;
				if (portion > remaining)
					portion = remaining;
				area += value * longint'(portion);
				filled += portion;
				remaining -= portion;
				if (filled >= in_len) begin
					quotient = area / longint'(in_len);
					if ((area % longint'(in_len)) != 0 && area < 0)
						quotient -= 1;
					emitted = (emitted + 1) & 'h1FFF;
					r.sample  = quotient[SW-1:0];
					// Another cell closes only if a whole cell's worth is left.
					r.run_end = (remaining < in_len);
					r.row_end = (emitted == out_len);
					due_outputs.push_back(r);
					area   = 0;
					filled = 0;
				end
			end
			taken = (taken + 1) & 'h1FFF;
			if (taken >= in_len)
				clear_row();
		endfunction

		// Compare one accepted output request with the oldest one due.
		function void check_output(logic signed [SW-1:0] s, logic re, logic ro);
			resampled_t want;
			if (due_outputs.size() == 0) begin
				$display({"%0t: unexpected output: expected none, ",
					"actual sample %0d run_end %0b row_end %0b"},
					$time, s, re, ro);
				errors++;
				return;
			end
			want = due_outputs.pop_front();
			if (s !== want.sample) begin
				$display("%0t: sample_out mismatch: expected %0d, actual %0d",
					$time, want.sample, s);
				errors++;
			end
			if (re !== want.run_end) begin
				$display("%0t: run_end mismatch: expected %0b, actual %0b",
					$time, want.run_end, re);
				errors++;
			end
			if (ro !== want.row_end) begin
				$display("%0t: row_end mismatch: expected %0b, actual %0b",
					$time, want.row_end, ro);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [SW-1:0] sample_in;
	logic out_valid;
	logic out_ready;
	logic signed [SW-1:0] sample_out;
	logic run_end;
	logic row_end;

	cell_area_predictor predictor;
	bit sender_gaps = 1'b1;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;

	area_based_line_resampler i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.run_end    (run_end),
		.row_end    (row_end)
	);

	always #5 clk = ~clk;

	// Watch both handshakes at every edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			predictor.check_output(sample_out, run_end, row_end);
		if (arst_n && in_valid && in_ready)
			predictor.take_sample(sample_in);
	end

	// Output side: random stalls, a long hold on demand, none in the quiet part.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	// Offer one sample, maybe after an idle burst, and wait for its request to be taken.
	task automatic offer_sample(input logic signed [SW-1:0] value);
		if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_requests();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending, let every due output arrive, then let the core go quiet.
	task automatic settle();
		pause_requests();
		while (predictor.due_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		predictor.write_length(index, data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Dropping output_length to one first makes any legal pair reachable.
	task automatic set_lengths(input int n, input int m);
		write_reg(REG_OUTPUT_LENGTH, 13'd1);
		write_reg(REG_INPUT_LENGTH, CFG_W'(n));
		write_reg(REG_OUTPUT_LENGTH, CFG_W'(m));
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		int sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SW'($urandom_range(0, 32) - 16);
			default: return SW'($urandom);
		endcase
	endfunction

	initial begin
		int random_count;
		int burst;
		int n;
		int m;
		int limit;
		int sel;

		predictor = new();
		random_count = 0;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_INPUT_LENGTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample_in = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset lengths: each sample passes straight through.
		offer_sample(SAMPLE_MAX);
		offer_sample(SAMPLE_MIN);
		offer_sample('0);
		offer_sample(-1);
		offer_sample(1);
		settle();

		// Writes out of range, above the ratio, or to unknown indexes change nothing.
		write_reg(REG_INPUT_LENGTH, 13'd0);
		write_reg(REG_INPUT_LENGTH, 13'd5000);
		write_reg(REG_INPUT_LENGTH, 13'd8191);
		write_reg(REG_OUTPUT_LENGTH, 13'd0);
		write_reg(REG_OUTPUT_LENGTH, 13'd4097);
		write_reg(REG_OUTPUT_LENGTH, 13'd64);
		write_reg(REG_UNUSED_2, 13'd8191);
		write_reg(REG_UNUSED_3, 13'd0);
		offer_sample(SAMPLE_MAX);
		settle();

		// Largest ratio with one input per row.
		write_reg(REG_OUTPUT_LENGTH, 13'd63);
		offer_sample(SAMPLE_MAX);
		offer_sample(SAMPLE_MIN);
		settle();

		// Uneven cells, leaving a partial row that the next write drops.
		write_reg(REG_INPUT_LENGTH, 13'd2);
		offer_sample(-1);
		offer_sample(SAMPLE_MAX);
		offer_sample(SAMPLE_MIN);
		settle();
		write_reg(REG_OUTPUT_LENGTH, 13'd126);
		write_reg(REG_INPUT_LENGTH, 13'd1);
		offer_sample(SAMPLE_MIN);
		offer_sample(24'sd12345);
		settle();

		// Halving, with negative averages that round down.
		write_reg(REG_OUTPUT_LENGTH, 13'd2);
		write_reg(REG_INPUT_LENGTH, 13'd4);
		offer_sample(SAMPLE_MAX);
		offer_sample(SAMPLE_MIN);
		offer_sample(-1);
		offer_sample(-2);
		settle();

		// Doubling.
		write_reg(REG_INPUT_LENGTH, 13'd3);
		write_reg(REG_OUTPUT_LENGTH, 13'd6);
		offer_sample(1);
		offer_sample(-3);
		offer_sample(7);
		settle();

		// Both lengths at their maximum.
		write_reg(REG_INPUT_LENGTH, 13'd4096);
		write_reg(REG_OUTPUT_LENGTH, 13'd4096);
		repeat (3) offer_sample(pick_sample());
		settle();

		// Output side holds off while samples keep coming, so the input stalls.
		set_lengths(1, 8);
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		repeat (12) offer_sample(pick_sample());
		settle();

		// Random phases, each with its own lengths and idling mix.
		while (random_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_INDEX_W'($urandom_range(0, 3)), CFG_W'($urandom));
			sel = $urandom_range(0, 9);
			if (sel < 7)
				n = $urandom_range(1, 12);
			else if (sel < 9)
				n = $urandom_range(13, 200);
			else
				n = $urandom_range(201, DEF_MAX_LENGTH);
			limit = MAX_RATIO * n;
			if (limit > DEF_MAX_LENGTH)
				limit = DEF_MAX_LENGTH;
			if ($urandom_range(0, 3) == 0)
				m = $urandom_range(1, limit);
			else
				m = $urandom_range(1, (4 * n < limit) ? 4 * n : limit);
			set_lengths(n, m);
			sender_gaps = ($urandom_range(0, 2) != 0);
			burst = $urandom_range(10, 40);
			repeat (burst) begin
				offer_sample(pick_sample());
				random_count++;
				if (random_count >= QUIET_FROM)
					quiet = 1'b1;
			end
			settle();
		end

		if (predictor.errors == 0)
			$display("area_based_line_resampler_tb: PASS");
		else
			$display("area_based_line_resampler_tb: FAIL");
		$finish;
	end

	// Hard limit on the run.
	initial begin
		#(TIMEOUT_NS);
		$display("area_based_line_resampler_tb: FAIL");
		$finish;
	end

endmodule

>>> area_based_line_resampler.f
hdl/alr_pkg.sv
hdl/alr_divider.sv
hdl/alr_datapath.sv
hdl/alr_ctrl.sv
hdl/area_based_line_resampler.sv
sim/area_based_line_resampler_tb.sv
